// ----- rtl/hufd_pkg.sv -----
package hufd_pkg;

    // Default tree size: leaves the store can hold
    localparam int MAX_LEAVES_DEF = 256;

    // Fixed field widths
    localparam int SYM_W  = 8;
    localparam int USYM_W = 9;

    // Leaf count target after reset
    localparam logic [USYM_W-1:0] USYM_RESET = 9'd256;

    // Action codes of an input transaction
    localparam logic [1:0] ACT_HDR   = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Status codes of a result transaction
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_TREE  = 2'd1;
    localparam logic [1:0] STAT_HDR_LATE = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic             leaf_flag;
        logic [SYM_W-1:0] leaf_symbol;
    } item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [1:0]       status;
    } result_t;

endpackage

// ----- rtl/hufd_ram.sv -----
module hufd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 511,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/huffman_tree_load_and_decode_unit.sv -----
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   hufd_pkg::item_t
// result    out        result_valid / result_stall hufd_pkg::result_t
// cfg       in         cfg_we                    cfg_wdata (leaf count target)
//
// Data bit: answered straight from S_IDLE when it needs no node read (no tree, leaf at
// the root, missing child), else one read of the node store, which has one read port.
// Header item: the root is written from S_IDLE; other nodes pass S_LD_PARENT, then one
// S_LD_CLIMB per full parent climbed, as each climb step is one dependent store read.
// Clear and unused actions finish in S_IDLE; the node store needs no clearing pass.
// A result that meets a stalled output register waits in a holding stage; no new
// item is taken until it moves on. rst_n clears all control state asynchronously.
module huffman_tree_load_and_decode_unit #(
    parameter int MAX_LEAVES = hufd_pkg::MAX_LEAVES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  hufd_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output hufd_pkg::result_t             result,
    input  logic                          cfg_we,
    input  logic [hufd_pkg::USYM_W-1:0]   cfg_wdata
);

    localparam int NODE_CAP = 2 * MAX_LEAVES - 1;
    localparam int IDX_W    = $clog2(NODE_CAP);
    localparam int CNT_W    = $clog2(NODE_CAP + 1);
    localparam int SYM_W    = hufd_pkg::SYM_W;
    localparam int USYM_W   = hufd_pkg::USYM_W;

    localparam logic [CNT_W-1:0]  NODE_CAP_C   = CNT_W'(NODE_CAP);
    localparam logic [USYM_W-1:0] MAX_LEAVES_C = USYM_W'(MAX_LEAVES);

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] kid0;
        logic [IDX_W-1:0] kid1;
        logic [IDX_W-1:0] up;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_PARENT,
        S_LD_CLIMB,
        S_DEC_CHK,
        S_HOLD
    } state_t;

    state_t                 state_reg, state_next;
    logic [USYM_W-1:0]      usym_reg, usym_next;
    logic [CNT_W-1:0]       nodes_reg, nodes_next;
    logic [IDX_W-1:0]       build_reg, build_next;
    logic [USYM_W-1:0]      leaves_reg, leaves_next;
    logic                   complete_reg, complete_next;
    logic [IDX_W-1:0]       dec_cur_reg, dec_cur_next;
    logic [IDX_W-1:0]       dec_kid0_reg, dec_kid0_next;
    logic [IDX_W-1:0]       dec_kid1_reg, dec_kid1_next;
    logic [IDX_W-1:0]       dec_nxt_reg, dec_nxt_next;
    logic                   root_leaf_reg, root_leaf_next;
    logic [SYM_W-1:0]       root_sym_reg, root_sym_next;
    logic [IDX_W-1:0]       root_kid0_reg, root_kid0_next;
    logic [IDX_W-1:0]       root_kid1_reg, root_kid1_next;
    logic                   hdr_leaf_reg, hdr_leaf_next;
    logic [IDX_W-1:0]       hdr_node_reg, hdr_node_next;
    logic [IDX_W-1:0]       walk_reg, walk_next;
    logic                   out_valid_reg, out_valid_next;
    hufd_pkg::result_t      out_reg, out_next;
    hufd_pkg::result_t      hold_reg, hold_next;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    node_t                  mem_wdata;
    logic [IDX_W-1:0]       mem_raddr;
    logic [NODE_W-1:0]      mem_rdata;

    node_t                  rd_node;
    node_t                  upd_node;
    node_t                  new_node;
    logic [USYM_W-1:0]      target;
    logic [USYM_W-1:0]      leaves_inc;
    logic [IDX_W-1:0]       cur_kid0;
    logic [IDX_W-1:0]       cur_kid1;
    logic [IDX_W-1:0]       dec_nxt;
    logic                   accept;
    logic                   out_free;
    logic                   res_valid;
    hufd_pkg::result_t      res_data;

    hufd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_CAP)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && (state_reg == S_IDLE);
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Decode node read data and attach the new node to the parent
    always_comb
    begin
        rd_node  = node_t'(mem_rdata);
        upd_node = rd_node;
        if (rd_node.kid0 == '0)
        begin
            upd_node.kid0 = hdr_node_reg;
        end
        else
        begin
            upd_node.kid1 = hdr_node_reg;
        end
    end

    // Clamp the leaf count target to 1 .. MAX_LEAVES
    always_comb
    begin
        if (usym_reg == '0)
        begin
            target = USYM_W'(1);
        end
        else if (usym_reg > MAX_LEAVES_C)
        begin
            target = MAX_LEAVES_C;
        end
        else
        begin
            target = usym_reg;
        end
    end

    assign leaves_inc = leaves_reg + USYM_W'(1);

    // Pick the decode cursor's children; the root keeps its own copy
    assign cur_kid0 = (dec_cur_reg == '0) ? root_kid0_reg : dec_kid0_reg;
    assign cur_kid1 = (dec_cur_reg == '0) ? root_kid1_reg : dec_kid1_reg;
    assign dec_nxt  = item.leaf_flag ? cur_kid1 : cur_kid0;

    // Build the entry of a new header node
    always_comb
    begin
        new_node.leaf = item.leaf_flag;
        new_node.sym  = item.leaf_flag ? item.leaf_symbol : '0;
        new_node.kid0 = '0;
        new_node.kid1 = '0;
        new_node.up   = (nodes_reg == '0) ? '0 : build_reg;
    end

    // Sequence header loading, decoding and result delivery
    always_comb
    begin
        state_next     = state_reg;
        usym_next      = cfg_we ? cfg_wdata : usym_reg;
        nodes_next     = nodes_reg;
        build_next     = build_reg;
        leaves_next    = leaves_reg;
        complete_next  = complete_reg;
        dec_cur_next   = dec_cur_reg;
        dec_kid0_next  = dec_kid0_reg;
        dec_kid1_next  = dec_kid1_reg;
        dec_nxt_next   = dec_nxt_reg;
        root_leaf_next = root_leaf_reg;
        root_sym_next  = root_sym_reg;
        root_kid0_next = root_kid0_reg;
        root_kid1_next = root_kid1_reg;
        hdr_leaf_next  = hdr_leaf_reg;
        hdr_node_next  = hdr_node_reg;
        walk_next      = walk_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;
        res_valid      = 1'b0;
        res_data       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.action)
                        hufd_pkg::ACT_CLEAR:
                        begin
                            nodes_next     = '0;
                            build_next     = '0;
                            leaves_next    = '0;
                            complete_next  = 1'b0;
                            dec_cur_next   = '0;
                            root_leaf_next = 1'b0;
                        end
                        hufd_pkg::ACT_HDR:
                        begin
                            if (complete_reg)
                            begin
                                res_valid       = 1'b1;
                                res_data.status = hufd_pkg::STAT_HDR_LATE;
                            end
                            else if (nodes_reg < NODE_CAP_C)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = nodes_reg[IDX_W-1:0];
                                mem_wdata  = new_node;
                                nodes_next = nodes_reg + CNT_W'(1);
                                if (nodes_reg == '0)
                                begin
                                    // Root node: a leaf here closes the tree at once
                                    build_next     = '0;
                                    root_leaf_next = item.leaf_flag;
                                    root_sym_next  = new_node.sym;
                                    root_kid0_next = '0;
                                    root_kid1_next = '0;
                                    if (item.leaf_flag)
                                    begin
                                        leaves_next   = USYM_W'(1);
                                        complete_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    mem_raddr     = build_reg;
                                    hdr_leaf_next = item.leaf_flag;
                                    hdr_node_next = nodes_reg[IDX_W-1:0];
                                    walk_next     = build_reg;
                                    state_next    = S_LD_PARENT;
                                end
                            end
                        end
                        hufd_pkg::ACT_DATA:
                        begin
                            if (!complete_reg)
                            begin
                                res_valid       = 1'b1;
                                res_data.status = hufd_pkg::STAT_NO_TREE;
                            end
                            else if (root_leaf_reg)
                            begin
                                res_valid       = 1'b1;
                                res_data.symbol = root_sym_reg;
                                res_data.status = hufd_pkg::STAT_OK;
                            end
                            else if (dec_nxt == '0)
                            begin
                                dec_cur_next    = '0;
                                res_valid       = 1'b1;
                                res_data.status = hufd_pkg::STAT_NO_TREE;
                            end
                            else
                            begin
                                mem_raddr    = dec_nxt;
                                dec_nxt_next = dec_nxt;
                                state_next   = S_DEC_CHK;
                            end
                        end
                        hufd_pkg::ACT_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LD_PARENT:
            begin
                // Write back the parent with the new child attached
                mem_we    = 1'b1;
                mem_waddr = walk_reg;
                mem_wdata = upd_node;
                if (walk_reg == '0)
                begin
                    root_kid0_next = upd_node.kid0;
                    root_kid1_next = upd_node.kid1;
                end
                if (!hdr_leaf_reg)
                begin
                    build_next = hdr_node_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    leaves_next = leaves_inc;
                    if ((upd_node.kid0 != '0) && (upd_node.kid1 != '0))
                    begin
                        if (walk_reg == '0)
                        begin
                            build_next    = '0;
                            complete_next = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            mem_raddr  = upd_node.up;
                            walk_next  = upd_node.up;
                            state_next = S_LD_CLIMB;
                        end
                    end
                    else
                    begin
                        build_next = walk_reg;
                        if (leaves_inc >= target)
                        begin
                            complete_next = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_LD_CLIMB:
            begin
                // Climb while the node has both children filled
                if ((rd_node.kid0 != '0) && (rd_node.kid1 != '0))
                begin
                    if (walk_reg == '0)
                    begin
                        build_next    = '0;
                        complete_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        mem_raddr = rd_node.up;
                        walk_next = rd_node.up;
                    end
                end
                else
                begin
                    build_next = walk_reg;
                    if (leaves_reg >= target)
                    begin
                        complete_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DEC_CHK:
            begin
                state_next = S_IDLE;
                if (rd_node.leaf)
                begin
                    dec_cur_next    = '0;
                    res_valid       = 1'b1;
                    res_data.symbol = rd_node.sym;
                    res_data.status = hufd_pkg::STAT_OK;
                end
                else
                begin
                    dec_cur_next  = dec_nxt_reg;
                    dec_kid0_next = rd_node.kid0;
                    dec_kid1_next = rd_node.kid1;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load the output register, or park the result while it is stalled
        if (res_valid)
        begin
            if (out_free)
            begin
                out_next       = res_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                hold_next  = res_data;
                state_next = S_HOLD;
            end
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            usym_reg      <= hufd_pkg::USYM_RESET;
            nodes_reg     <= '0;
            build_reg     <= '0;
            leaves_reg    <= '0;
            complete_reg  <= 1'b0;
            dec_cur_reg   <= '0;
            dec_kid0_reg  <= '0;
            dec_kid1_reg  <= '0;
            dec_nxt_reg   <= '0;
            root_leaf_reg <= 1'b0;
            root_sym_reg  <= '0;
            root_kid0_reg <= '0;
            root_kid1_reg <= '0;
            hdr_leaf_reg  <= 1'b0;
            hdr_node_reg  <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            hold_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            usym_reg      <= usym_next;
            nodes_reg     <= nodes_next;
            build_reg     <= build_next;
            leaves_reg    <= leaves_next;
            complete_reg  <= complete_next;
            dec_cur_reg   <= dec_cur_next;
            dec_kid0_reg  <= dec_kid0_next;
            dec_kid1_reg  <= dec_kid1_next;
            dec_nxt_reg   <= dec_nxt_next;
            root_leaf_reg <= root_leaf_next;
            root_sym_reg  <= root_sym_next;
            root_kid0_reg <= root_kid0_next;
            root_kid1_reg <= root_kid1_next;
            hdr_leaf_reg  <= hdr_leaf_next;
            hdr_node_reg  <= hdr_node_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            hold_reg      <= hold_next;
        end
    end

endmodule

// ----- rtl/hufd_chk.sv -----
module hufd_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_stall,
    input hufd_pkg::item_t             item,
    input logic                        result_valid,
    input logic                        result_stall,
    input hufd_pkg::result_t           result,
    input logic                        cfg_we
);

    logic item_take;

    assign item_take = item_valid && !item_stall;

    // Hold a stalled result transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result transaction changed or dropped");

    // Drive symbol to zero on every error status
    a_err_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != hufd_pkg::STAT_OK) |-> (result.symbol == '0))
        else $error("error result carries a nonzero symbol");

    // Be ready for a new item in the cycle after a clear
    a_clear_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && (item.action == hufd_pkg::ACT_CLEAR) |=> !item_stall)
        else $error("clear transaction did not finish in one cycle");

    // Produce nothing for the unused action
    a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && (item.action == hufd_pkg::ACT_NONE) && !result_valid
        && !cfg_we |=> !result_valid)
        else $error("unused action produced a result");

endmodule

bind huffman_tree_load_and_decode_unit hufd_chk u_hufd_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int SYM_W        = hufd_pkg::SYM_W;
    localparam int USYM_W       = hufd_pkg::USYM_W;
    localparam int MAX_LEAVES   = hufd_pkg::MAX_LEAVES_DEF;
    localparam int NODE_CAP     = 2 * MAX_LEAVES - 1;
    // Worst header item: one climb per node of a chain, plus margin
    localparam int SETTLE_CYC   = NODE_CAP + 16;
    localparam int STALL_LIMIT  = 8000;
    localparam int RANDOM_ITEMS = 40;

    // Tracks the code tree, predicts each result and checks what comes out
    class decode_scoreboard;
        bit                  node_leaf [NODE_CAP];
        logic [SYM_W-1:0]    node_sym  [NODE_CAP];
        int unsigned         node_kid0 [NODE_CAP];
        int unsigned         node_kid1 [NODE_CAP];
        int unsigned         node_up   [NODE_CAP];
        int unsigned         nodes_used;
        int unsigned         build_at;
        int unsigned         leaves_seen;
        int unsigned         decode_at;
        bit                  complete;
        logic [USYM_W-1:0]   leaf_goal;
        hufd_pkg::result_t   symbols_due [$];
        int                  errors;
        int                  n_decoded;
        int                  n_no_tree;
        int                  n_late_hdr;

        function new();
            leaf_goal  = hufd_pkg::USYM_RESET;
            errors     = 0;
            n_decoded  = 0;
            n_no_tree  = 0;
            n_late_hdr = 0;
            clear_tree();
        endfunction

        function void clear_tree();
            for (int i = 0; i < NODE_CAP; i++)
            begin
                node_leaf[i] = 1'b0;
                node_sym[i]  = '0;
                node_kid0[i] = 0;
                node_kid1[i] = 0;
                node_up[i]   = 0;
            end
            nodes_used  = 0;
            build_at    = 0;
            leaves_seen = 0;
            decode_at   = 0;
            complete    = 1'b0;
        endfunction

        // Zero counts as one, anything above the store size as the store size
        function int unsigned leaf_limit();
            if (leaf_goal == 0)
                return 1;
            if (leaf_goal > MAX_LEAVES)
                return MAX_LEAVES;
            return leaf_goal;
        endfunction

        // Attach one pre-order node under the build cursor, then climb past full parents
        function void add_node(logic leaf, logic [SYM_W-1:0] sym);
            int unsigned n;
            int unsigned p;
            int unsigned steps;
            bit          closed;
            closed = 1'b0;
            steps  = 0;
            // Drop the item when the store is full
            if (nodes_used >= NODE_CAP)
                return;
            n = nodes_used;
            node_leaf[n] = leaf;
            node_sym[n]  = leaf ? sym : '0;
            node_kid0[n] = 0;
            node_kid1[n] = 0;
            nodes_used   = n + 1;
            if (n == 0)
            begin
                node_up[0] = 0;
                build_at   = 0;
                if (leaf)
                begin
                    leaves_seen = 1;
                    complete    = 1'b1;
                end
                return;
            end
            p = build_at;
            node_up[n] = p;
            if (node_kid0[p] == 0)
                node_kid0[p] = n;
            else
                node_kid1[p] = n;
            if (!leaf)
            begin
                build_at = n;
                return;
            end
            leaves_seen = (leaves_seen + 1) & 'h1FF;
            while (node_kid0[p] != 0 && node_kid1[p] != 0)
            begin
                // A full root means no free slot is left anywhere
                if (p == 0 || steps >= NODE_CAP)
                begin
                    closed = 1'b1;
                    break;
                end
                p = node_up[p];
                steps++;
            end
            build_at = p;
            if (closed || leaves_seen >= leaf_limit())
                complete = 1'b1;
        endfunction

        // Advance the tree state by one transaction; return 1 when it yields a result
        function bit step_decoder(input hufd_pkg::item_t it, output hufd_pkg::result_t res);
            int unsigned nxt;
            res = '0;
            case (it.action)
                hufd_pkg::ACT_CLEAR:
                begin
                    clear_tree();
                    return 1'b0;
                end
                hufd_pkg::ACT_HDR:
                begin
                    if (complete)
                    begin
                        res.status = hufd_pkg::STAT_HDR_LATE;
                        return 1'b1;
                    end
                    add_node(it.leaf_flag, it.leaf_symbol);
                    return 1'b0;
                end
                hufd_pkg::ACT_DATA:
                begin
                    if (!complete)
                    begin
                        res.status = hufd_pkg::STAT_NO_TREE;
                        return 1'b1;
                    end
                    // A leaf at the root answers every bit
                    if (node_leaf[0])
                    begin
                        res.symbol = node_sym[0];
                        res.status = hufd_pkg::STAT_OK;
                        return 1'b1;
                    end
                    nxt = it.leaf_flag ? node_kid1[decode_at] : node_kid0[decode_at];
                    if (nxt == 0)
                    begin
                        decode_at  = 0;
                        res.status = hufd_pkg::STAT_NO_TREE;
                        return 1'b1;
                    end
                    if (node_leaf[nxt])
                    begin
                        decode_at  = 0;
                        res.symbol = node_sym[nxt];
                        res.status = hufd_pkg::STAT_OK;
                        return 1'b1;
                    end
                    decode_at = nxt;
                    return 1'b0;
                end
                default:
                    return 1'b0;
            endcase
        endfunction

        function void note_item(hufd_pkg::item_t it);
            hufd_pkg::result_t want;
            if (step_decoder(it, want))
                symbols_due.push_back(want);
        endfunction

        function void check_result(hufd_pkg::result_t got);
            hufd_pkg::result_t want;
            if (symbols_due.size() == 0)
            begin
                $error("unexpected result transaction: symbol %02h status %0d",
                       got.symbol, got.status);
                errors++;
                return;
            end
            want = symbols_due.pop_front();
            if (got.symbol !== want.symbol)
            begin
                $error("symbol: expected %02h, actual %02h", want.symbol, got.symbol);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            case (want.status)
                hufd_pkg::STAT_OK:       n_decoded++;
                hufd_pkg::STAT_NO_TREE:  n_no_tree++;
                default:                 n_late_hdr++;
            endcase
        endfunction

        function int pending();
            return symbols_due.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    hufd_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall = 1'b0;
    hufd_pkg::result_t result;
    logic              cfg_we;
    logic [USYM_W-1:0] cfg_wdata;

    decode_scoreboard  sb;
    hufd_pkg::item_t   hdr_q [$];
    int                burst_left = 0;
    int                fed = 0;
    int                idle_cycles = 0;
    int                stall_mode = 0;
    int                stall_left = 0;
    int                stall_tick = 0;

    huffman_tree_load_and_decode_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Observe both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(result);
            if (item_valid && !item_stall)
                sb.note_item(item);
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result stall pattern: free, light random, heavy random and periodic stretches
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            2:       result_stall <= ($urandom_range(0, 99) < 70);
            default: result_stall <= ((stall_tick % 5) < 2);
        endcase
    end

    // Send one transaction in bursts with random gaps; return at the next falling edge
    task automatic put(input logic [1:0] act, input logic flag, input logic [SYM_W-1:0] sym);
        hufd_pkg::item_t it;
        int              gap;
        it.action      = act;
        it.leaf_flag   = flag;
        it.leaf_symbol = sym;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        burst_left--;
        if (act != hufd_pkg::ACT_NONE)
            fed++;
        @(negedge clk);
    endtask

    // Hold off until every expected result is back and the block has gone quiet
    task automatic settle();
        item_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_goal(input logic [USYM_W-1:0] value);
        settle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.leaf_goal = value;
    endtask

    // Emit a random pre-order header for a tree of the given leaf count
    function automatic void push_tree(input int leaves);
        hufd_pkg::item_t it;
        int              split;
        it.action      = hufd_pkg::ACT_HDR;
        it.leaf_flag   = (leaves == 1);
        it.leaf_symbol = SYM_W'($urandom_range(0, 255));
        hdr_q.push_back(it);
        if (leaves > 1)
        begin
            split = $urandom_range(1, leaves - 1);
            push_tree(split);
            push_tree(leaves - split);
        end
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [SYM_W-1:0] rand_sym();
        return SYM_W'($urandom_range(0, 255));
    endfunction

    task automatic put_noise(input bit allow_hdr);
        case ($urandom_range(0, allow_hdr ? 2 : 1))
            0:       put(hufd_pkg::ACT_NONE, rand_bit(), rand_sym());
            1:       put(hufd_pkg::ACT_DATA, rand_bit(), rand_sym());
            default: put(hufd_pkg::ACT_HDR, rand_bit(), rand_sym());
        endcase
    endtask

    task automatic run_directed();
        // Data before any tree, then an unused action
        put(hufd_pkg::ACT_DATA, 1'b1, 8'h00);
        put(hufd_pkg::ACT_NONE, 1'b1, 8'hFF);
        // Leaf at the root: every bit yields its symbol, further headers are late
        put(hufd_pkg::ACT_HDR, 1'b1, 8'hFF);
        put(hufd_pkg::ACT_DATA, 1'b0, 8'h00);
        put(hufd_pkg::ACT_DATA, 1'b1, 8'hFF);
        put(hufd_pkg::ACT_HDR, 1'b0, 8'h00);
        // Structure closes before the leaf count target is reached
        put(hufd_pkg::ACT_CLEAR, 1'b1, 8'hFF);
        put(hufd_pkg::ACT_HDR, 1'b0, 8'hFF);
        put(hufd_pkg::ACT_HDR, 1'b1, 8'h00);
        put(hufd_pkg::ACT_HDR, 1'b1, 8'h5A);
        put(hufd_pkg::ACT_DATA, 1'b0, 8'hFF);
        put(hufd_pkg::ACT_DATA, 1'b1, 8'h00);
        put(hufd_pkg::ACT_CLEAR, 1'b0, 8'h00);
        // Target reached with a slot still open: the open side is a missing child
        write_goal(9'd2);
        put(hufd_pkg::ACT_HDR, 1'b0, 8'h00);
        put(hufd_pkg::ACT_HDR, 1'b0, 8'h00);
        put(hufd_pkg::ACT_HDR, 1'b1, 8'hA5);
        put(hufd_pkg::ACT_HDR, 1'b1, 8'h3C);
        put(hufd_pkg::ACT_DATA, 1'b0, 8'h00);
        put(hufd_pkg::ACT_DATA, 1'b0, 8'h00);
        put(hufd_pkg::ACT_DATA, 1'b1, 8'h00);
        put(hufd_pkg::ACT_DATA, 1'b0, 8'h00);
        put(hufd_pkg::ACT_DATA, 1'b1, 8'h00);
        put(hufd_pkg::ACT_HDR, 1'b1, 8'h11);
        // A target of zero behaves as one
        write_goal(9'd0);
        put(hufd_pkg::ACT_CLEAR, 1'b0, 8'h00);
        put(hufd_pkg::ACT_HDR, 1'b0, 8'h00);
        put(hufd_pkg::ACT_HDR, 1'b1, 8'h81);
        put(hufd_pkg::ACT_DATA, 1'b1, 8'h00);
        put(hufd_pkg::ACT_DATA, 1'b0, 8'h00);
    endtask

    task automatic run_table_fill();
        // Chain of internal nodes fills the store; later headers are dropped
        write_goal(9'd511);
        put(hufd_pkg::ACT_CLEAR, 1'b0, 8'h00);
        for (int i = 0; i < NODE_CAP - 1; i++)
            put(hufd_pkg::ACT_HDR, 1'b0, rand_sym());
        put(hufd_pkg::ACT_HDR, 1'b1, 8'h77);
        repeat (3) put(hufd_pkg::ACT_HDR, rand_bit(), rand_sym());
        put(hufd_pkg::ACT_DATA, 1'b0, 8'h00);
    endtask

    task automatic run_random();
        int start;
        int leaves;
        int goal;
        int cut;
        int pick;
        start = fed;
        while (fed - start < RANDOM_ITEMS)
        begin
            pick   = $urandom_range(0, 99);
            leaves = (pick < 10) ? 1 : (pick < 85) ? $urandom_range(2, 12)
                                                   : $urandom_range(13, 64);
            // Pick a target equal to, above or below the real leaf count
            pick = $urandom_range(0, 99);
            if (pick < 65 || leaves == 1)
                goal = leaves;
            else if (pick < 82)
                goal = $urandom_range(leaves + 1, 511);
            else
                goal = $urandom_range(0, leaves - 1);
            if (goal != sb.leaf_goal)
                write_goal(USYM_W'(goal));
            hdr_q.delete();
            push_tree(leaves);
            // Now and then cut the header short
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, hdr_q.size() - 1)
                                              : hdr_q.size();
            put(hufd_pkg::ACT_CLEAR, rand_bit(), rand_sym());
            for (int i = 0; i < cut; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    put_noise(sb.complete);
                // Retarget in the middle of a load
                if (i == cut / 2 && $urandom_range(0, 19) == 0)
                    write_goal(USYM_W'($urandom_range(0, 511)));
                put(hufd_pkg::ACT_HDR, hdr_q[i].leaf_flag, hdr_q[i].leaf_symbol);
            end
            repeat ($urandom_range(6, 40))
            begin
                if ($urandom_range(0, 11) == 0)
                    put_noise(1'b1);
                put(hufd_pkg::ACT_DATA, rand_bit(), rand_sym());
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_table_fill();
        run_random();
        settle();

        $display("covered %0d transactions over directed, full-store and random tree loads",
                 fed);
        $display("results seen: %0d decoded, %0d without tree, %0d late header",
                 sb.n_decoded, sb.n_no_tree, sb.n_late_hdr);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
